FILE: hdl/line_clip_midpoint_bisect_defines.svh
// ----------------------------------------------------------------------------
// Line clip assertion macros
// Shared property shorthands for the checker of the line clipping block.
// ----------------------------------------------------------------------------
`ifndef LINE_CLIP_MIDPOINT_BISECT_DEFINES_SVH
`define LINE_CLIP_MIDPOINT_BISECT_DEFINES_SVH

// Antecedent implies consequent on the same edge, outside reset.
`define LCMB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line clip check failed");

// Antecedent implies consequent on the next edge, outside reset.
`define LCMB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line clip check failed");

// Consequent holds on the edge after reset is seen.
`define LCMB_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("line clip reset check failed");

`endif

FILE: hdl/lcmb_pkg.sv
// ----------------------------------------------------------------------------
// Line clip package
// Constants, microcode format and the microcode program of the clipper.
// ----------------------------------------------------------------------------
package lcmb_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP    = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT  = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM = 8'd3;

  // outcode bit positions
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_TOP    = 2;
  localparam int OC_BOTTOM = 3;
  typedef logic [3:0] outcode_t;

  // bisection iteration cap
  localparam int ITER_BITS = 7;
  localparam logic [ITER_BITS-1:0] ITER_CAP = 7'd100;

  localparam int STEP_BITS = 4;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_CODES  = 4'd1;
  localparam step_t ST_PT     = 4'd2;
  localparam step_t ST_XSET   = 4'd3;
  localparam step_t ST_YSET   = 4'd4;
  localparam step_t ST_MIDM   = 4'd5;
  localparam step_t ST_MIDO   = 4'd6;
  localparam step_t ST_STEPM  = 4'd7;
  localparam step_t ST_STEPO  = 4'd8;
  localparam step_t ST_DONE   = 4'd9;
  localparam step_t ST_AXCHK  = 4'd10;
  localparam step_t ST_FAIL   = 4'd11;
  localparam step_t ST_NEXT   = 4'd14;
  localparam step_t ST_FIN    = 4'd15;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD_X,
    OP_LOAD_Y,
    OP_MID_MAIN,
    OP_MID_OTHER,
    OP_STEP_MAIN,
    OP_STEP_OTHER,
    OP_TAKE,
    OP_NEXT_PT,
    OP_FAIL,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_ACC,
    C_REJECT,
    C_CODE_ZERO,
    C_HAS_LR,
    C_NO_TB,
    C_HIT,
    C_IN_WIN,
    C_AXIS_X,
    C_FIRST_PT,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic acc;
    logic reject;
    logic code_zero;
    logic has_lr;
    logic no_tb;
    logic hit;
    logic in_win;
    logic axis_x;
    logic first_pt;
    logic out_busy;
  } flags_t;

  // Jump to target when cond holds, else fall through to the next step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      ST_IDLE:  w = '{op: OP_ACCEPT,     cond: C_NOT_ACC,   target: ST_IDLE};
      ST_CODES: w = '{op: OP_NONE,       cond: C_REJECT,    target: ST_FAIL};
      ST_PT:    w = '{op: OP_NONE,       cond: C_CODE_ZERO, target: ST_NEXT};
      ST_XSET:  w = '{op: OP_LOAD_X,     cond: C_HAS_LR,    target: ST_MIDM};
      ST_YSET:  w = '{op: OP_LOAD_Y,     cond: C_NO_TB,     target: ST_FAIL};
      ST_MIDM:  w = '{op: OP_MID_MAIN,   cond: C_NEVER,     target: ST_IDLE};
      ST_MIDO:  w = '{op: OP_MID_OTHER,  cond: C_NEVER,     target: ST_IDLE};
      ST_STEPM: w = '{op: OP_STEP_MAIN,  cond: C_HIT,       target: ST_DONE};
      ST_STEPO: w = '{op: OP_STEP_OTHER, cond: C_ALWAYS,    target: ST_STEPM};
      ST_DONE:  w = '{op: OP_TAKE,       cond: C_IN_WIN,    target: ST_NEXT};
      ST_AXCHK: w = '{op: OP_NONE,       cond: C_AXIS_X,    target: ST_YSET};
      ST_FAIL:  w = '{op: OP_FAIL,       cond: C_ALWAYS,    target: ST_FIN};
      ST_NEXT:  w = '{op: OP_NEXT_PT,    cond: C_FIRST_PT,  target: ST_PT};
      // fall through wraps to idle once the result register is free
      ST_FIN:   w = '{op: OP_EMIT,       cond: C_OUT_BUSY,  target: ST_FIN};
      default:  w = '{op: OP_NONE,       cond: C_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/lcmb_seq.sv
// ----------------------------------------------------------------------------
// Line clip sequencer
// Step counter and microcode ROM with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module lcmb_seq import lcmb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output uword_t uw
);

  step_t step;
  step_t step_next;
  logic  take;

  assign uw = ucode(step);

  always_comb begin
    case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_ACC:   take = !flags.acc;
      C_REJECT:    take = flags.reject;
      C_CODE_ZERO: take = flags.code_zero;
      C_HAS_LR:    take = flags.has_lr;
      C_NO_TB:     take = flags.no_tb;
      C_HIT:       take = flags.hit;
      C_IN_WIN:    take = flags.in_win;
      C_AXIS_X:    take = flags.axis_x;
      C_FIRST_PT:  take = flags.first_pt;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b1;
    endcase
    step_next = take ? uw.target : step_t'(step + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: hdl/line_clip_midpoint_bisect.sv
// ----------------------------------------------------------------------------
// Line clip by midpoint bisection
// Clips one segment against a configured window with a microcoded datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries the two endpoints of a segment.
//   Output channel (out_valid/out_stall) carries visible and the clipped
//   endpoints; an invisible segment comes back unchanged with visible low.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the window
//   edges left, top, right, bottom at indexes 0..3; other indexes are dropped.
//   Write the window only while the block is idle. cfg_ready is always high.
//   One segment is worked on at a time; in_stall is low only in the idle step.
//   Each endpoint search runs on one shared adder: a load step, the midpoint
//   steps, then halving steps until the midpoint meets the edge, stops
//   moving or ITER_CAP is reached. A segment needs up to two searches per
//   endpoint outside the window, up to four searches in all. The finished
//   beat sits in the output register; the next segment is taken while it
//   waits, and only the final step holds on out_stall.
//   Reset (rst, synchronous) clears the window to zero and drops any
//   pending beat.
// ----------------------------------------------------------------------------
module line_clip_midpoint_bisect import lcmb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         visible,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  localparam int W = COORD_BITS;
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

  uword_t uw;
  flags_t flags;

  logic signed [W-1:0] win_l, win_t, win_r, win_b;
  logic signed [W-1:0] sx1, sy1, sx2, sy2;
  logic [W-1:0] gl, gt_e, gr, gb;
  logic [W-1:0] gx1, gy1, gx2, gy2;
  logic [W-1:0] px, py, qx, qy;
  outcode_t c1, c2, code_p;

  logic [W-1:0] lo, hi, lo_o, hi_o, m, mo, edge_c;
  logic [W-1:0] tx1, ty1, tx2, ty2;
  logic [ITER_BITS-1:0] n;
  logic dir, axis_y, pt, vis;

  logic [W-1:0] add_a, add_b, half;
  logic [W:0]   sum;
  logic         m_gt, in_win, out_busy;

  lcmb_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uw    (uw)
  );

  assign in_stall  = rst || (uw.op != OP_ACCEPT);
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && out_stall;

  // offset binary, so the search compares unsigned
  assign gl   = win_l ^ SIGN;
  assign gt_e = win_t ^ SIGN;
  assign gr   = win_r ^ SIGN;
  assign gb   = win_b ^ SIGN;
  assign gx1  = sx1 ^ SIGN;
  assign gy1  = sy1 ^ SIGN;
  assign gx2  = sx2 ^ SIGN;
  assign gy2  = sy2 ^ SIGN;

  always_comb begin
    c1[OC_LEFT]   = sx1 < win_l;
    c1[OC_RIGHT]  = !c1[OC_LEFT] && (sx1 > win_r);
    c1[OC_TOP]    = sy1 < win_t;
    c1[OC_BOTTOM] = !c1[OC_TOP] && (sy1 > win_b);
    c2[OC_LEFT]   = sx2 < win_l;
    c2[OC_RIGHT]  = !c2[OC_LEFT] && (sx2 > win_r);
    c2[OC_TOP]    = sy2 < win_t;
    c2[OC_BOTTOM] = !c2[OC_TOP] && (sy2 > win_b);
  end

  assign px     = pt ? gx2 : gx1;
  assign py     = pt ? gy2 : gy1;
  assign qx     = pt ? gx1 : gx2;
  assign qy     = pt ? gy1 : gy2;
  assign code_p = pt ? c2 : c1;

  // shared adder: every midpoint is the floor of the widened sum halved
  assign m_gt = m > edge_c;

  always_comb begin
    case (uw.op)
      OP_MID_MAIN: begin
        add_a = lo;
        add_b = hi;
      end
      OP_MID_OTHER: begin
        add_a = lo_o;
        add_b = hi_o;
      end
      OP_STEP_MAIN: begin
        add_a = m;
        add_b = m_gt ? lo : hi;
      end
      OP_STEP_OTHER: begin
        add_a = mo;
        add_b = dir ? lo_o : hi_o;
      end
      default: begin
        add_a = m;
        add_b = mo;
      end
    endcase
    sum  = {1'b0, add_a} + {1'b0, add_b};
    half = sum[W:1];
  end

  assign in_win = axis_y ? ((mo >= gl) && (mo <= gr)) : ((mo >= gt_e) && (mo <= gb));

  always_comb begin
    flags.acc       = in_valid && !in_stall;
    flags.reject    = (c1 & c2) != '0;
    flags.code_zero = code_p == '0;
    flags.has_lr    = code_p[OC_LEFT] || code_p[OC_RIGHT];
    flags.no_tb     = !(code_p[OC_TOP] || code_p[OC_BOTTOM]);
    flags.hit       = (m == edge_c) || (n == ITER_CAP) || (half == m);
    flags.in_win    = in_win;
    flags.axis_x    = !axis_y;
    flags.first_pt  = !pt;
    flags.out_busy  = out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_l <= '0;
      win_t <= '0;
      win_r <= '0;
      win_b <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT:   win_l <= cfg_data;
        REG_TOP:    win_t <= cfg_data;
        REG_RIGHT:  win_r <= cfg_data;
        REG_BOTTOM: win_b <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_ACCEPT: begin
        if (flags.acc) begin
          sx1 <= start_x;
          sy1 <= start_y;
          sx2 <= end_x;
          sy2 <= end_y;
          tx1 <= start_x ^ SIGN;
          ty1 <= start_y ^ SIGN;
          tx2 <= end_x ^ SIGN;
          ty2 <= end_y ^ SIGN;
          vis <= 1'b1;
          pt  <= 1'b0;
        end
      end
      OP_LOAD_X: begin
        axis_y <= 1'b0;
        if (code_p[OC_LEFT]) begin
          lo <= px; lo_o <= py; hi <= qx; hi_o <= qy; edge_c <= gl;
        end else begin
          lo <= qx; lo_o <= qy; hi <= px; hi_o <= py; edge_c <= gr;
        end
      end
      OP_LOAD_Y: begin
        axis_y <= 1'b1;
        if (code_p[OC_TOP]) begin
          lo <= py; lo_o <= px; hi <= qy; hi_o <= qx; edge_c <= gt_e;
        end else begin
          lo <= qy; lo_o <= qx; hi <= py; hi_o <= px; edge_c <= gb;
        end
      end
      OP_MID_MAIN: begin
        m <= half;
        n <= '0;
      end
      OP_MID_OTHER: begin
        mo <= half;
      end
      OP_STEP_MAIN: begin
        // move the end on the midpoint's side of the edge to the midpoint
        if (m_gt) begin
          hi <= m;
        end else begin
          lo <= m;
        end
        m   <= half;
        dir <= m_gt;
      end
      OP_STEP_OTHER: begin
        if (dir) begin
          hi_o <= mo;
        end else begin
          lo_o <= mo;
        end
        mo <= half;
        n  <= n + 1'b1;
      end
      OP_TAKE: begin
        if (in_win) begin
          if (pt) begin
            tx2 <= axis_y ? mo : edge_c;
            ty2 <= axis_y ? edge_c : mo;
          end else begin
            tx1 <= axis_y ? mo : edge_c;
            ty1 <= axis_y ? edge_c : mo;
          end
        end
      end
      OP_NEXT_PT: begin
        pt <= 1'b1;
      end
      OP_FAIL: begin
        vis <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // drop the bias on the way out; an invisible segment returns its input
  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT && !out_busy) begin
      visible         <= vis;
      clipped_start_x <= vis ? (tx1 ^ SIGN) : sx1;
      clipped_start_y <= vis ? (ty1 ^ SIGN) : sy1;
      clipped_end_x   <= vis ? (tx2 ^ SIGN) : sx2;
      clipped_end_y   <= vis ? (ty2 ^ SIGN) : sy2;
    end
  end

endmodule

FILE: hdl/lcmb_chk.sv
// ----------------------------------------------------------------------------
// Line clip checker
// Port level checks of the clipper's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_clip_midpoint_bisect_defines.svh"

module lcmb_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // no result beat survives reset
  `LCMB_ASSERT_RESET(a_rst_clears_out, !out_valid)

  // after taking a segment the block is busy with it
  `LCMB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a stalled result stays offered
  `LCMB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // a new result only comes from a segment in work
  `LCMB_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind line_clip_midpoint_bisect lcmb_chk u_lcmb_chk (.*);
